[src/assert_macros.svh]
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/mmcc_pkg.sv]
`default_nettype none
package mmcc_pkg;

  // Command codes
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Line states
  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_t;

  // Result codes
  typedef enum logic [2:0] {
    OUT_RD_HIT  = 3'd0,
    OUT_WR_HIT  = 3'd1,
    OUT_RD_MISS = 3'd2,
    OUT_WR_MISS = 3'd3,
    OUT_PRELOAD = 3'd4
  } outcome_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV0,
    S_DIV1,
    S_DIV2,
    S_DIV3,
    S_LOOK,
    S_HIT_RD,
    S_PEER,
    S_PSET,
    S_FL_RD,
    S_FL_WR,
    S_FI_RD,
    S_FI_WR,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

[src/mesi_multi_cache_coherence.sv]
// From acceptance to result strobe: a preload ends once its address is reduced modulo MEM_WORDS,
// a write hit on E or M at the lookup, a read hit after a word-store read, a write hit on S after
// the peer walk, a miss after the victim, peer walk and fill. A valid victim and each peer copy
// holding the block are walked word by word: a read state, then a write state for dirty words.
// One transaction at a time: busy stays high from acceptance until the result strobe.
// After reset a clearing pass zeroes every main-memory word with busy high.
`default_nettype none
module mesi_multi_cache_coherence #(
  parameter int NUM_CACHES      = 4,
  parameter int LINES_PER_CACHE = 4,
  parameter int BLOCK_WORDS     = 4,
  parameter int MEM_WORDS       = 256,
  parameter int DATA_BITS       = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [1:0]  in_cache_id,
  input  wire logic [7:0]  in_address,
  input  wire logic [15:0] in_write_data,
  output logic             out_valid,
  output logic [2:0]       out_outcome,
  output logic [15:0]      out_read_data,
  output logic [1:0]       out_line_state,
  output logic [1:0]       out_line_slot,
  output logic [2:0]       out_words_written_back
);
  import mmcc_pkg::*;

  localparam int CW  = $clog2(NUM_CACHES);
  localparam int PCW = $clog2(NUM_CACHES + 1);
  localparam int SW  = $clog2(LINES_PER_CACHE);
  localparam int TL  = NUM_CACHES * LINES_PER_CACHE;
  localparam int LW  = $clog2(TL);
  localparam int TW  = TL * BLOCK_WORDS;
  localparam int TWW = $clog2(TW);
  localparam int AW  = $clog2(MEM_WORDS);
  localparam int OW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int WW  = $clog2(BLOCK_WORDS + 1);
  localparam int XW  = (AW > 8) ? AW : 8;
  localparam int SH  = 16;
  localparam int PW  = XW + SH + 1;
  localparam int RM  = (1 << SH) / MEM_WORDS;
  localparam int RB  = (1 << SH) / BLOCK_WORDS;
  localparam int WDW = DATA_BITS + 1;

  // line number of a slot in a cache
  function automatic logic [LW-1:0] lidx(input logic [CW-1:0] c, input logic [SW-1:0] s);
    return LW'(c) * LW'(LINES_PER_CACHE) + LW'(s);
  endfunction

  // word store index of a word in a line
  function automatic logic [TWW-1:0] widx(input logic [LW-1:0] l, input logic [WW-1:0] w);
    return TWW'(l) * TWW'(BLOCK_WORDS) + TWW'(w);
  endfunction

  // memory address of a block word, wrapped once
  function automatic logic [AW-1:0] memidx(input logic [AW-1:0] b, input logic [WW-1:0] w);
    logic [AW:0] t;
    t = (AW+1)'(b) * (AW+1)'(BLOCK_WORDS) + (AW+1)'(w);
    if (t >= (AW+1)'(MEM_WORDS)) t = t - (AW+1)'(MEM_WORDS);
    return AW'(t);
  endfunction

  state_t state_r, state_nxt;

  // transaction registers
  logic [1:0]           cmd_r, cmd_nxt;
  logic                 wr_r, wr_nxt;
  logic [CW-1:0]        c_r, c_nxt;
  logic [XW-1:0]        xin_r, xin_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [AW-1:0]        blk_r, blk_nxt;
  logic [OW-1:0]        off_r, off_nxt;
  logic [LW-1:0]        ln_r, ln_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic                 miss_r, miss_nxt;
  logic                 shared_r, shared_nxt;
  logic [PCW-1:0]       p_r, p_nxt;
  logic [WW-1:0]        w_r, w_nxt;
  logic [LW-1:0]        fl_r, fl_nxt;
  logic                 fl_own_r, fl_own_nxt;
  logic [WW-1:0]        wb_r, wb_nxt;
  logic [DATA_BITS-1:0] rdv_r, rdv_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;

  // result registers
  logic                 ov_r, ov_nxt;
  outcome_t             oo_r, oo_nxt;
  logic [DATA_BITS-1:0] od_r, od_nxt;
  mesi_t                os_r, os_nxt;
  logic [SW-1:0]        osl_r, osl_nxt;
  logic [WW-1:0]        owb_r, owb_nxt;

  // per-line and per-cache state in flip-flops
  mesi_t         mesi_r [TL];
  logic [AW-1:0] blkarr_r [TL];
  logic [SW-1:0] ptr_r [NUM_CACHES];

  logic          mesi_we, blk_we, ptr_we;
  logic [LW-1:0] mesi_wi;
  mesi_t         mesi_wd;
  logic [SW-1:0] ptr_wd;

  // RAM ports; the word store keeps the dirty bit above each data word
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [DATA_BITS-1:0] mem_wd, mem_rd;
  logic                 wram_we;
  logic [TWW-1:0]       wram_wa, wram_ra;
  logic [WDW-1:0]       wram_wd, wram_rd;

  mmcc_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  mmcc_ram #(.WIDTH(WDW), .DEPTH(TW)) u_words (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_wa),
    .wdata (wram_wd),
    .raddr (wram_ra),
    .rdata (wram_rd)
  );

  // cache number folded into range
  logic [3:0] cid4, cidm;
  assign cid4 = 4'(in_cache_id);
  assign cidm = (cid4 >= 4'(NUM_CACHES)) ? cid4 - 4'(NUM_CACHES) : cid4;

  // reciprocal division step with one correction
  logic [XW:0]   qv;
  logic [PW-1:0] dsel, rv_raw, rv;
  always_comb begin
    qv     = prod_r[PW-1:SH];
    dsel   = (state_r == S_DIV1) ? PW'(MEM_WORDS) : PW'(BLOCK_WORDS);
    rv_raw = (state_r == S_DIV1) ? PW'(xin_r) - PW'(qv) * PW'(MEM_WORDS)
                                 : PW'(xin_r) - PW'(qv) * PW'(BLOCK_WORDS);
    rv     = (rv_raw >= dsel) ? rv_raw - dsel : rv_raw;
  end

  // tag match of every line against the current block
  logic [TL-1:0] m;
  always_comb begin
    for (int l = 0; l < TL; l++) begin
      m[l] = (mesi_r[l] != MESI_I) && (blkarr_r[l] == blk_r);
    end
  end

  // first matching slot in the requesting cache and in the current peer
  logic          own_hit, peer_hit, peer_take;
  logic [SW-1:0] own_slot, peer_slot;
  logic [CW-1:0] pidx;
  logic [LW-1:0] hit_ln, peer_ln;
  always_comb begin
    pidx      = (p_r < PCW'(NUM_CACHES)) ? p_r[CW-1:0] : '0;
    own_hit   = 1'b0;
    own_slot  = '0;
    peer_hit  = 1'b0;
    peer_slot = '0;
    for (int s = LINES_PER_CACHE - 1; s >= 0; s--) begin
      if (m[lidx(c_r, SW'(s))]) begin
        own_hit  = 1'b1;
        own_slot = SW'(s);
      end
      if (m[lidx(pidx, SW'(s))]) begin
        peer_hit  = 1'b1;
        peer_slot = SW'(s);
      end
    end
    hit_ln    = lidx(c_r, own_slot);
    peer_ln   = lidx(pidx, peer_slot);
    peer_take = peer_hit && (pidx != c_r);
  end

  logic [TWW-1:0]       fl_k;
  logic                 fill_sel, w_end;
  logic [DATA_BITS-1:0] fill_wd;
  mesi_t                fin_state;
  logic [SW-1:0]        vs;
  assign fl_k      = widx(fl_r, w_r);
  assign w_end     = (w_r == WW'(BLOCK_WORDS));
  assign fill_sel  = wr_r && (w_r == WW'(off_r));
  assign fill_wd   = fill_sel ? data_r : mem_rd;
  assign fin_state = wr_r ? MESI_M : (shared_r ? MESI_S : MESI_E);
  assign vs        = ptr_r[c_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (start && (in_cmd != CMD_NONE)) state_nxt = S_DIV0;
      S_DIV0:   state_nxt = S_DIV1;
      S_DIV1:   state_nxt = (cmd_r == CMD_PRELOAD) ? S_IDLE : S_DIV2;
      S_DIV2:   state_nxt = S_DIV3;
      S_DIV3:   state_nxt = S_LOOK;
      S_LOOK: begin
        if (!own_hit) state_nxt = S_FL_RD;
        else if (!wr_r) state_nxt = S_HIT_RD;
        else if (mesi_r[hit_ln] == MESI_S) state_nxt = S_PEER;
        else state_nxt = S_IDLE;
      end
      S_HIT_RD: state_nxt = S_IDLE;
      S_PEER: begin
        if (p_r == PCW'(NUM_CACHES)) state_nxt = miss_r ? S_FI_RD : S_IDLE;
        else if (peer_take) state_nxt = S_FL_RD;
      end
      S_PSET:   state_nxt = S_PEER;
      S_FL_RD: begin
        if (w_end) state_nxt = fl_own_r ? S_PEER : S_PSET;
        else state_nxt = S_FL_WR;
      end
      S_FL_WR:  state_nxt = S_FL_RD;
      S_FI_RD:  state_nxt = w_end ? S_FIN : S_FI_WR;
      S_FI_WR:  state_nxt = S_FI_RD;
      S_FIN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    cmd_nxt = cmd_r;       wr_nxt = wr_r;         c_nxt = c_r;
    xin_nxt = xin_r;       prod_nxt = prod_r;     data_nxt = data_r;
    blk_nxt = blk_r;       off_nxt = off_r;       ln_nxt = ln_r;
    slot_nxt = slot_r;     miss_nxt = miss_r;     shared_nxt = shared_r;
    p_nxt = p_r;           w_nxt = w_r;           fl_nxt = fl_r;
    fl_own_nxt = fl_own_r; wb_nxt = wb_r;         rdv_nxt = rdv_r;
    clr_nxt = clr_r;
    ov_nxt = 1'b0;         oo_nxt = oo_r;         od_nxt = od_r;
    os_nxt = os_r;         osl_nxt = osl_r;       owb_nxt = owb_r;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;
    wram_we = 1'b0; wram_wa = '0; wram_wd = '0; wram_ra = '0;
    mesi_we = 1'b0; mesi_wi = '0; mesi_wd = MESI_I;
    blk_we = 1'b0;
    ptr_we = 1'b0;  ptr_wd = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (start && (in_cmd != CMD_NONE)) begin
          cmd_nxt  = in_cmd;
          wr_nxt   = (in_cmd == CMD_WRITE);
          c_nxt    = CW'(cidm);
          xin_nxt  = XW'(in_address);
          data_nxt = DATA_BITS'(in_write_data);
        end
      end
      S_DIV0: prod_nxt = PW'(xin_r) * PW'(RM);
      S_DIV1: begin
        xin_nxt = XW'(rv);
        if (cmd_r == CMD_PRELOAD) begin
          mem_we  = 1'b1;
          mem_wa  = AW'(rv);
          mem_wd  = data_r;
          ov_nxt  = 1'b1;
          oo_nxt  = OUT_PRELOAD;
          od_nxt  = data_r;
          os_nxt  = MESI_I;
          osl_nxt = '0;
          owb_nxt = '0;
        end
      end
      S_DIV2: prod_nxt = PW'(xin_r) * PW'(RB);
      S_DIV3: begin
        blk_nxt = AW'(qv);
        off_nxt = OW'(rv);
      end
      S_LOOK: begin
        if (own_hit) begin
          ln_nxt   = hit_ln;
          slot_nxt = own_slot;
          if (!wr_r) begin
            wram_ra = widx(hit_ln, WW'(off_r));
          end else begin
            wram_we  = 1'b1;
            wram_wa  = widx(hit_ln, WW'(off_r));
            wram_wd  = {1'b1, data_r};
            if (mesi_r[hit_ln] == MESI_S) begin
              p_nxt    = '0;
              miss_nxt = 1'b0;
            end else begin
              mesi_we = 1'b1;
              mesi_wi = hit_ln;
              mesi_wd = MESI_M;
              ov_nxt  = 1'b1;
              oo_nxt  = OUT_WR_HIT;
              od_nxt  = data_r;
              os_nxt  = MESI_M;
              osl_nxt = own_slot;
              owb_nxt = '0;
            end
          end
        end else begin
          // FIFO victim, pointer advances on misses only
          ptr_we     = 1'b1;
          ptr_wd     = (vs == SW'(LINES_PER_CACHE - 1)) ? '0 : vs + 1'b1;
          ln_nxt     = lidx(c_r, vs);
          slot_nxt   = vs;
          fl_nxt     = lidx(c_r, vs);
          fl_own_nxt = 1'b1;
          // an invalid victim holds no dirty words, so its walk is skipped
          w_nxt      = (mesi_r[lidx(c_r, vs)] == MESI_I) ? WW'(BLOCK_WORDS) : '0;
          wb_nxt     = '0;
          shared_nxt = 1'b0;
          miss_nxt   = 1'b1;
        end
      end
      S_HIT_RD: begin
        ov_nxt  = 1'b1;
        oo_nxt  = OUT_RD_HIT;
        od_nxt  = wram_rd[DATA_BITS-1:0];
        os_nxt  = mesi_r[ln_r];
        osl_nxt = slot_r;
        owb_nxt = '0;
      end
      S_PEER: begin
        if (p_r == PCW'(NUM_CACHES)) begin
          w_nxt = '0;
          if (!miss_r) begin
            mesi_we = 1'b1;
            mesi_wi = ln_r;
            mesi_wd = MESI_M;
            ov_nxt  = 1'b1;
            oo_nxt  = OUT_WR_HIT;
            od_nxt  = data_r;
            os_nxt  = MESI_M;
            osl_nxt = slot_r;
            owb_nxt = '0;
          end
        end else if (peer_take) begin
          fl_nxt     = peer_ln;
          fl_own_nxt = 1'b0;
          w_nxt      = '0;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_PSET: begin
        // peer copy is clean now: shared on a read, gone on a write
        mesi_we    = 1'b1;
        mesi_wi    = fl_r;
        mesi_wd    = wr_r ? MESI_I : MESI_S;
        shared_nxt = 1'b1;
        p_nxt      = p_r + 1'b1;
      end
      S_FL_RD: begin
        if (w_end) begin
          if (fl_own_r) p_nxt = '0;
        end else begin
          wram_ra = fl_k;
        end
      end
      S_FL_WR: begin
        // dirty word goes back to memory and is marked clean
        if (wram_rd[DATA_BITS]) begin
          mem_we  = 1'b1;
          mem_wa  = memidx(blkarr_r[fl_r], w_r);
          mem_wd  = wram_rd[DATA_BITS-1:0];
          wram_we = 1'b1;
          wram_wa = fl_k;
          wram_wd = {1'b0, wram_rd[DATA_BITS-1:0]};
          if (fl_own_r) wb_nxt = wb_r + 1'b1;
        end
        w_nxt = w_r + 1'b1;
      end
      S_FI_RD: begin
        if (!w_end) mem_ra = memidx(blk_r, w_r);
      end
      S_FI_WR: begin
        wram_we  = 1'b1;
        wram_wa  = widx(ln_r, w_r);
        wram_wd  = {fill_sel, fill_wd};
        if (w_r == WW'(off_r)) rdv_nxt = fill_wd;
        w_nxt    = w_r + 1'b1;
      end
      S_FIN: begin
        blk_we  = 1'b1;
        mesi_we = 1'b1;
        mesi_wi = ln_r;
        mesi_wd = fin_state;
        ov_nxt  = 1'b1;
        oo_nxt  = wr_r ? OUT_WR_MISS : OUT_RD_MISS;
        od_nxt  = rdv_r;
        os_nxt  = fin_state;
        osl_nxt = slot_r;
        owb_nxt = wb_r;
      end
      default: ;
    endcase
  end

  // control state and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      for (int l = 0; l < TL; l++) begin
        mesi_r[l]   <= MESI_I;
        blkarr_r[l] <= '0;
      end
      for (int c = 0; c < NUM_CACHES; c++) ptr_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (mesi_we) mesi_r[mesi_wi] <= mesi_wd;
      if (blk_we) blkarr_r[ln_r] <= blk_r;
      if (ptr_we) ptr_r[c_r] <= ptr_wd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;       wr_r <= wr_nxt;         c_r <= c_nxt;
    xin_r <= xin_nxt;       prod_r <= prod_nxt;     data_r <= data_nxt;
    blk_r <= blk_nxt;       off_r <= off_nxt;       ln_r <= ln_nxt;
    slot_r <= slot_nxt;     miss_r <= miss_nxt;     shared_r <= shared_nxt;
    p_r <= p_nxt;           w_r <= w_nxt;           fl_r <= fl_nxt;
    fl_own_r <= fl_own_nxt; wb_r <= wb_nxt;         rdv_r <= rdv_nxt;
    oo_r <= oo_nxt;         od_r <= od_nxt;         os_r <= os_nxt;
    osl_r <= osl_nxt;       owb_r <= owb_nxt;
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = ov_r;
  assign out_outcome            = oo_r;
  assign out_read_data          = 16'(od_r);
  assign out_line_state         = os_r;
  assign out_line_slot          = 2'(osl_r);
  assign out_words_written_back = 3'(owb_r);

endmodule
`default_nettype wire

[src/mmcc_ram.sv]
`default_nettype none
module mmcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[src/mmcc_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module mmcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_outcome,
  input wire logic [1:0]  out_line_state,
  input wire logic [1:0]  out_line_slot,
  input wire logic [2:0]  out_words_written_back
);
  import mmcc_pkg::*;

  // a transaction yields at most one strobe, never two in a row
  `ASSERT_NEXT(a_no_double, clk, rst_n, out_valid, !out_valid)

  // the strobe comes with the block ready for the next transaction
  `ASSERT_IMPLY(a_idle_strobe, clk, rst_n, out_valid, !busy)

  // preload reports no line
  `ASSERT_IMPLY(a_preload_zero, clk, rst_n, out_valid && (out_outcome == OUT_PRELOAD),
    (out_line_state == MESI_I) && (out_line_slot == 2'd0) && (out_words_written_back == 3'd0))

  // every write leaves the line modified
  `ASSERT_IMPLY(a_write_m, clk, rst_n,
    out_valid && ((out_outcome == OUT_WR_HIT) || (out_outcome == OUT_WR_MISS)),
    out_line_state == MESI_M)

  // hits evict nothing
  `ASSERT_IMPLY(a_hit_no_wb, clk, rst_n,
    out_valid && ((out_outcome == OUT_RD_HIT) || (out_outcome == OUT_WR_HIT)),
    (out_words_written_back == 3'd0) && (out_line_state != MESI_I))

endmodule

bind mesi_multi_cache_coherence mmcc_checker u_mmcc_checker (.*);
`default_nettype wire
